// File: design/rgb_to_hsv_pixel_converter_top_macros.svh
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RGBHSV_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rgbhsv assertion failed");

// next-cycle implication, disabled during reset
`define RGBHSV_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rgbhsv assertion failed");

`endif

// File: design/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int SAT_W  = 7;
  localparam int T_W    = 11;
  localparam int HNUM_W = 17;
  localparam int SNUM_W = 15;

  localparam int DIV_STEPS = HUE_W;

  localparam int HUE_SCALE  = 60;
  localparam int SAT_SCALE  = 100;
  localparam int SECTORS    = 6;
  localparam int HUE_WRAP   = SECTORS * HUE_SCALE;

  localparam logic signed [T_W:0] GREEN_MULT = 2;
  localparam logic signed [T_W:0] BLUE_MULT  = 4;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [HNUM_W-1:0] hnum;
    logic [SNUM_W-1:0] snum;
    logic [CH_W-1:0]   d;
    logic [CH_W-1:0]   mx;
    logic              neg;
    logic              grey;
    logic [CH_W-1:0]   hrem;
    logic [CH_W-1:0]   srem;
    logic [HUE_W-1:0]  hq;
    logic [SAT_W-1:0]  sq;
  } div_t;

endpackage

// File: design/rgb_to_hsv_pixel_converter_top.sv
// channel   dir  tdata fields (lsb first)                 tuser  tlast
// s_axis    in   red[7:0] green[15:8] blue[23:16]         -      -
// m_axis    out  hue[8:0] saturation[15:9] value[23:16]   -      -
//
// one pixel per clock while m_axis is not stalled, through a compare stage, a
// numerator stage, nine restoring divider stages (one hue quotient bit each,
// the seven saturation bits in the first seven of them) and the output register
// rst is synchronous, clears every stage valid bit and holds s_axis_tready low
// a stall on m_axis holds the whole pipeline; s_axis_tready follows it
module rgb_to_hsv_pixel_converter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [3*rgbhsv_pkg::CH_W-1:0] s_axis_tdata,  // red, green, blue
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rgbhsv_pkg::HUE_W+rgbhsv_pkg::SAT_W+rgbhsv_pkg::CH_W-1:0]
                                      m_axis_tdata   // hue, saturation, value
);
  import rgbhsv_pkg::*;

  logic adv;

  // compare stage
  logic [CH_W-1:0] red, green, blue;
  logic [CH_W-1:0] mx_c, mn_c;
  sector_t         sec_c;
  logic signed [CH_W:0] diff_c;

  logic                 b_valid;
  sector_t              b_sec;
  logic [CH_W-1:0]      b_mx;
  logic [CH_W-1:0]      b_d;
  logic signed [CH_W:0] b_diff;
  logic                 b_grey;

  // divider pipeline
  div_t dv  [0:DIV_STEPS];
  logic vld [0:DIV_STEPS];
  div_t dv0_next;
  logic signed [T_W:0] diff_ext, d_ext, tsum;
  logic [T_W-1:0] tval;

  // output register
  logic [HUE_W-1:0] out_hue, hue_next;
  logic [SAT_W-1:0] out_sat, sat_next;
  logic [CH_W-1:0]  out_val;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !rst;
  assign m_axis_tdata  = {out_val, out_sat, out_hue};

  assign red   = s_axis_tdata[CH_W-1:0];
  assign green = s_axis_tdata[2*CH_W-1:CH_W];
  assign blue  = s_axis_tdata[3*CH_W-1:2*CH_W];

  // ties go to red, then green
  always_comb begin
    if (red >= green && red >= blue) begin
      sec_c  = SEC_RED;
      mx_c   = red;
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sec_c  = SEC_GREEN;
      mx_c   = green;
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_c  = SEC_BLUE;
      mx_c   = blue;
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sec  <= sec_c;
      b_mx   <= mx_c;
      b_d    <= mx_c - mn_c;
      b_diff <= diff_c;
      b_grey <= (mx_c == mn_c);
    end
  end

  // numerators: 60*(diff + k*d) for hue (60*|diff| in the red sector), 100*d for saturation
  always_comb begin
    diff_ext = {{(T_W-CH_W){b_diff[CH_W]}}, b_diff};
    d_ext    = $signed({{(T_W+1-CH_W){1'b0}}, b_d});
    unique case (b_sec)
      SEC_RED:   tsum = (diff_ext < 0) ? -diff_ext : diff_ext;
      SEC_GREEN: tsum = diff_ext + d_ext * GREEN_MULT;
      SEC_BLUE:  tsum = diff_ext + d_ext * BLUE_MULT;
      default:   tsum = diff_ext;
    endcase
    tval = tsum[T_W-1:0];

    dv0_next.hnum = HNUM_W'(tval * HUE_SCALE);
    dv0_next.snum = SNUM_W'(b_d * SAT_SCALE);
    dv0_next.d    = b_d;
    dv0_next.mx   = b_mx;
    dv0_next.neg  = (b_sec == SEC_RED) && (diff_ext < 0);
    dv0_next.grey = b_grey;
    dv0_next.hrem = dv0_next.hnum[HNUM_W-1:HUE_W];
    dv0_next.srem = dv0_next.snum[SNUM_W-1:SAT_W];
    dv0_next.hq   = '0;
    dv0_next.sq   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [CH_W:0]    htrial;
    logic [CH_W-1:0]  srem_n;
    logic [SAT_W-1:0] sq_n;
    div_t             nxt;

    if (k < SAT_W) begin : g_sat
      logic [CH_W:0] strial;
      always_comb begin
        strial = {dv[k].srem, dv[k].snum[SAT_W-1-k]};
        if (strial >= {1'b0, dv[k].mx}) begin
          srem_n = CH_W'(strial - {1'b0, dv[k].mx});
          sq_n   = {dv[k].sq[SAT_W-2:0], 1'b1};
        end else begin
          srem_n = strial[CH_W-1:0];
          sq_n   = {dv[k].sq[SAT_W-2:0], 1'b0};
        end
      end
    end else begin : g_sat_done
      assign srem_n = dv[k].srem;
      assign sq_n   = dv[k].sq;
    end

    always_comb begin
      nxt    = dv[k];
      htrial = {dv[k].hrem, dv[k].hnum[HUE_W-1-k]};
      if (htrial >= {1'b0, dv[k].d}) begin
        nxt.hrem = CH_W'(htrial - {1'b0, dv[k].d});
        nxt.hq   = {dv[k].hq[HUE_W-2:0], 1'b1};
      end else begin
        nxt.hrem = htrial[CH_W-1:0];
        nxt.hq   = {dv[k].hq[HUE_W-2:0], 1'b0};
      end
      nxt.srem = srem_n;
      nxt.sq   = sq_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // grey pixels give zero hue and saturation; a negative red-sector quotient wraps by a full turn
  always_comb begin
    if (dv[DIV_STEPS].grey) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      if (dv[DIV_STEPS].neg && dv[DIV_STEPS].hq != '0) begin
        hue_next = HUE_W'(HUE_WRAP) - dv[DIV_STEPS].hq;
      end else begin
        hue_next = dv[DIV_STEPS].hq;
      end
      sat_next = dv[DIV_STEPS].sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue <= hue_next;
      out_sat <= sat_next;
      out_val <= dv[DIV_STEPS].mx;
    end
  end

endmodule

// File: design/rgbhsv_checker.sv
`include "rgb_to_hsv_pixel_converter_top_macros.svh"

module rgbhsv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rgbhsv_pkg::HUE_W+rgbhsv_pkg::SAT_W+rgbhsv_pkg::CH_W-1:0]
                                     m_axis_tdata
);
  import rgbhsv_pkg::*;

  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] sat;
  logic [CH_W-1:0]  val;

  assign hue = m_axis_tdata[HUE_W-1:0];
  assign sat = m_axis_tdata[HUE_W+SAT_W-1:HUE_W];
  assign val = m_axis_tdata[HUE_W+SAT_W+CH_W-1:HUE_W+SAT_W];

  `RGBHSV_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
  `RGBHSV_ASSERT_NOW(a_hue_range, m_axis_tvalid, hue < HUE_W'(HUE_WRAP))
  `RGBHSV_ASSERT_NOW(a_black_zero, m_axis_tvalid && val == '0, hue == '0 && sat == '0)
  `RGBHSV_ASSERT_NOW(a_ready_follow, m_axis_tready, s_axis_tready)

endmodule

bind rgb_to_hsv_pixel_converter_top rgbhsv_checker u_rgbhsv_checker (.*);
